/* sv/baro_pressure_compensation_macros.svh */
// assertion macros shared by the checker of the pressure compensation block
// no dependencies; included by files that hold concurrent assertions
`ifndef BARO_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_PRESSURE_COMPENSATION_MACROS_SVH

// property checked only outside reset
`define BPC_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every edge, reset included
`define BPC_ASSERT_ALL(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/bpc_pkg.sv */
// shared widths, register indexes and constants of the pressure compensation block
// no dependencies; imported by baro_pressure_compensation
`default_nettype none

package bpc_pkg;

    // field and register widths
    localparam int unsigned RAW_W     = 24;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned PRES_W    = 32;
    localparam int unsigned TEMPC_W   = 21;

    // internal datapath widths
    localparam int unsigned DT_W      = 25;  // temperature difference
    localparam int unsigned PROD_W    = 42;  // dt times a calibration word
    localparam int unsigned DD_W      = 50;  // dt squared
    localparam int unsigned TEMP1_W   = 20;  // first-order temperature
    localparam int unsigned T2_W      = 19;  // second-order temperature term
    localparam int unsigned SQR_W     = 40;  // squared temperature offsets
    localparam int unsigned CORR_W    = 42;  // offset and sensitivity
    localparam int unsigned HALF_W    = 21;  // split point of the final multiply
    localparam int unsigned PP_HI_W   = 46;
    localparam int unsigned PP_LO_W   = 45;
    localparam int unsigned FIN_W     = 48;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SENS      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TEMP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 3'd5;

    // temperature thresholds in hundredths of a degree
    localparam int T_REF  = 2000;
    localparam int T_COLD = -1500;

    // shift amounts
    localparam int unsigned SH_TEMP = 23;
    localparam int unsigned SH_OFF  = 7;
    localparam int unsigned SH_SENS = 8;
    localparam int unsigned SH_T2   = 31;
    localparam int unsigned SH_P    = 15;

    typedef logic signed [DT_W-1:0]    t_dt;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [TEMP1_W-1:0] t_temp1;
    typedef logic signed [CORR_W-1:0]  t_corr;
    typedef logic signed [SQR_W-1:0]   t_sqr;

endpackage

`default_nettype wire

/* sv/baro_pressure_compensation.sv */
// second-order temperature compensated pressure and temperature, seven stage pipeline
// depends on bpc_pkg
//
// usage:
//   a request carries one raw pressure and one raw temperature conversion
//   (24 bits each) on i_in_valid / o_in_ready. each request yields exactly one
//   result, pressure in pascals (low 32 bits) and temperature in hundredths of
//   a degree, on o_out_valid / i_out_ready, in request order.
//   the six calibration words are written through i_cfg_wr_en / i_cfg_idx /
//   i_cfg_data while no request is in flight; indexes 6 and 7 are ignored.
//   one request per cycle is taken while no result is stalled; the rate is
//   set by the pipeline of multipliers (dt products, squared corrections,
//   then a two-part 24 x 42 bit final product).
//   reset clears all calibration words and every stage valid bit.
//   when the receiver stalls with a result pending, the whole pipeline holds
//   and o_in_ready drops in the same cycle; nothing is lost or repeated.
`default_nettype none

module baro_pressure_compensation (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_wr_en,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [bpc_pkg::CFG_W-1:0]            i_cfg_data,
    // request side
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [bpc_pkg::RAW_W-1:0]            i_pressure_raw,
    input  logic [bpc_pkg::RAW_W-1:0]            i_temp_raw,
    // result side
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [bpc_pkg::PRES_W-1:0]    o_pressure_pa,
    output logic signed [bpc_pkg::TEMPC_W-1:0]   o_temp_centi
);
    import bpc_pkg::*;

    // calibration words
    logic [CFG_W-1:0] r_sens_coeff, r_off_coeff, r_sens_temp, r_off_temp;
    logic [CFG_W-1:0] r_ref_temp, r_temp_slope;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens_coeff <= '0;
            r_off_coeff  <= '0;
            r_sens_temp  <= '0;
            r_off_temp   <= '0;
            r_ref_temp   <= '0;
            r_temp_slope <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_SENS:      r_sens_coeff <= i_cfg_data;
                REG_OFF:       r_off_coeff  <= i_cfg_data;
                REG_SENS_TEMP: r_sens_temp  <= i_cfg_data;
                REG_OFF_TEMP:  r_off_temp   <= i_cfg_data;
                REG_REF_TEMP:  r_ref_temp   <= i_cfg_data;
                REG_SLOPE:     r_temp_slope <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance: everything moves unless a result is stuck at the output
    logic w_adv;
    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // stage valid bits
    logic [6:1] r_v;
    logic       r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v         <= {r_v[5:1], i_in_valid};
            r_out_valid <= r_v[6];
        end
    end
    assign o_out_valid = r_out_valid;

    // ---------------- stage 1: temperature difference
    logic [RAW_W+1:0] w_dt_full;
    t_dt              n_dt, r_dt;
    logic [RAW_W-1:0] r_d1_s1;

    assign w_dt_full = {2'b00, i_temp_raw} - {2'b00, r_ref_temp, 8'h00};
    assign n_dt      = w_dt_full[DT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dt    <= n_dt;
            r_d1_s1 <= i_pressure_raw;
        end
    end

    // ---------------- stage 2: dt products
    t_prod                  n_m_t, n_m_o, n_m_s, r_m_t, r_m_o, r_m_s;
    logic signed [DD_W-1:0] n_m_dd, r_m_dd;
    logic [RAW_W-1:0]       r_d1_s2;

    assign n_m_t  = r_dt * $signed({1'b0, r_temp_slope});
    assign n_m_o  = r_dt * $signed({1'b0, r_off_temp});
    assign n_m_s  = r_dt * $signed({1'b0, r_sens_temp});
    assign n_m_dd = r_dt * r_dt;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_t   <= n_m_t;
            r_m_o   <= n_m_o;
            r_m_s   <= n_m_s;
            r_m_dd  <= n_m_dd;
            r_d1_s2 <= r_d1_s1;
        end
    end

    // ---------------- stage 3: first-order temperature, offset, sensitivity
    t_prod                  w_temp1_full;
    t_temp1                 n_temp1, r_temp1_s3;
    t_corr                  n_off1, n_sens1, r_off1_s3, r_sens1_s3;
    logic signed [T2_W-1:0] n_t2, r_t2_s3;
    logic [RAW_W-1:0]       r_d1_s3;

    assign w_temp1_full = (r_m_t >>> SH_TEMP) + PROD_W'(T_REF);
    assign n_temp1      = w_temp1_full[TEMP1_W-1:0];
    assign n_off1       = $signed(CORR_W'({r_off_coeff, 16'h0000})) + (r_m_o >>> SH_OFF);
    assign n_sens1      = $signed(CORR_W'({r_sens_coeff, 15'h0000})) + (r_m_s >>> SH_SENS);
    // dt squared is never negative and stays below 2^48
    assign n_t2         = {2'b00, r_m_dd[DD_W-3:SH_T2]};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_temp1_s3 <= n_temp1;
            r_off1_s3  <= n_off1;
            r_sens1_s3 <= n_sens1;
            r_t2_s3    <= n_t2;
            r_d1_s3    <= r_d1_s2;
        end
    end

    // ---------------- stage 4: squares of the distance below the thresholds
    t_temp1                 w_below, w_cold;
    t_sqr                   n_sq_b, n_sq_c, r_sq_b, r_sq_c;
    logic                   n_warm_lt, n_cold_lt, r_warm_lt, r_cold_lt;
    t_temp1                 r_temp1_s4;
    t_corr                  r_off1_s4, r_sens1_s4;
    logic signed [T2_W-1:0] r_t2_s4;
    logic [RAW_W-1:0]       r_d1_s4;

    assign w_below   = r_temp1_s3 - TEMP1_W'(T_REF);
    assign w_cold    = r_temp1_s3 - TEMP1_W'(T_COLD);
    assign n_sq_b    = w_below * w_below;
    assign n_sq_c    = w_cold * w_cold;
    assign n_warm_lt = r_temp1_s3 < TEMP1_W'(T_REF);
    assign n_cold_lt = r_temp1_s3 < TEMP1_W'(T_COLD);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_b     <= n_sq_b;
            r_sq_c     <= n_sq_c;
            r_warm_lt  <= n_warm_lt;
            r_cold_lt  <= n_cold_lt;
            r_temp1_s4 <= r_temp1_s3;
            r_off1_s4  <= r_off1_s3;
            r_sens1_s4 <= r_sens1_s3;
            r_t2_s4    <= r_t2_s3;
            r_d1_s4    <= r_d1_s3;
        end
    end

    // ---------------- stage 5: second-order correction
    t_corr                     w_sq_b, w_sq_c, w_b5, w_c7, w_c11, w_off2, w_sens2;
    t_corr                     n_off, n_sens, r_off_s5, r_sens_s5;
    logic signed [TEMPC_W-1:0] n_temp, r_temp_s5;
    logic [RAW_W-1:0]          r_d1_s5;

    assign w_sq_b  = CORR_W'(r_sq_b);
    assign w_sq_c  = CORR_W'(r_sq_c);
    assign w_b5    = (w_sq_b <<< 2) + w_sq_b;
    assign w_c7    = (w_sq_c <<< 3) - w_sq_c;
    assign w_c11   = (w_sq_c <<< 3) + (w_sq_c <<< 1) + w_sq_c;
    assign w_off2  = (w_b5 >>> 1) + (r_cold_lt ? w_c7 : '0);
    assign w_sens2 = (w_b5 >>> 2) + (r_cold_lt ? (w_c11 >>> 1) : '0);

    always_comb begin
        if (r_warm_lt) begin
            n_temp = TEMPC_W'(r_temp1_s4) - TEMPC_W'(r_t2_s4);
            n_off  = r_off1_s4 - w_off2;
            n_sens = r_sens1_s4 - w_sens2;
        end else begin
            n_temp = TEMPC_W'(r_temp1_s4);
            n_off  = r_off1_s4;
            n_sens = r_sens1_s4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_temp_s5 <= n_temp;
            r_off_s5  <= n_off;
            r_sens_s5 <= n_sens;
            r_d1_s5   <= r_d1_s4;
        end
    end

    // ---------------- stage 6: pressure times sensitivity, split in two halves
    logic signed [PP_HI_W-1:0] n_pp_hi, r_pp_hi;
    logic [PP_LO_W-1:0]        n_pp_lo, r_pp_lo;
    t_corr                     r_off_s6;
    logic signed [TEMPC_W-1:0] r_temp_s6;

    assign n_pp_hi = $signed({1'b0, r_d1_s5}) * $signed(r_sens_s5[CORR_W-1:HALF_W]);
    assign n_pp_lo = r_d1_s5 * r_sens_s5[HALF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pp_hi   <= n_pp_hi;
            r_pp_lo   <= n_pp_lo;
            r_off_s6  <= r_off_s5;
            r_temp_s6 <= r_temp_s5;
        end
    end

    // ---------------- stage 7: combine, remove offset, scale to pascals
    // the low half product is never negative, so its floor shift is a plain shift
    logic signed [FIN_W-1:0]   w_x, w_diff;
    logic signed [PRES_W-1:0]  n_pressure, r_pressure;
    logic signed [TEMPC_W-1:0] r_temp_out;

    assign w_x        = FIN_W'(r_pp_hi) + $signed(FIN_W'(r_pp_lo[PP_LO_W-1:HALF_W]));
    assign w_diff     = w_x - FIN_W'(r_off_s6);
    assign n_pressure = w_diff[PRES_W+SH_P-1:SH_P];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pressure <= n_pressure;
            r_temp_out <= r_temp_s6;
        end
    end

    assign o_pressure_pa = r_pressure;
    assign o_temp_centi  = r_temp_out;

endmodule

`default_nettype wire

/* sv/bpc_checker.sv */
// port-level checks of the pressure compensation block, bound to its top level
// depends on baro_pressure_compensation_macros.svh and bpc_pkg
`default_nettype none
`include "baro_pressure_compensation_macros.svh"

module bpc_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                o_in_ready,
    input wire logic                                o_out_valid,
    input wire logic                                i_out_ready,
    input wire logic signed [bpc_pkg::PRES_W-1:0]   o_pressure_pa,
    input wire logic signed [bpc_pkg::TEMPC_W-1:0]  o_temp_centi
);

    // reset empties the output stage
    `BPC_ASSERT_ALL(a_rst_clears, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // a stalled result holds its payload
    `BPC_ASSERT_RUN(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pressure_pa) && $stable(o_temp_centi), "stalled result changed")

    // requests are taken whenever the output is free
    `BPC_ASSERT_RUN(a_ready_free, i_clk, i_rst_n, !o_out_valid || i_out_ready |-> o_in_ready, "request side blocked with output free")

    // no request is taken while the output is stuck
    `BPC_ASSERT_RUN(a_ready_stall, i_clk, i_rst_n, o_out_valid && !i_out_ready |-> !o_in_ready, "request taken during output stall")

endmodule

bind baro_pressure_compensation bpc_checker u_bpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pressure_pa (o_pressure_pa),
    .o_temp_centi  (o_temp_centi)
);

`default_nettype wire
